// File: src/adsr_envelope_one_pole_core_macros.svh
// assertion macros used by the checker file
`ifndef ADSR_ENVELOPE_ONE_POLE_CORE_MACROS_SVH
`define ADSR_ENVELOPE_ONE_POLE_CORE_MACROS_SVH

// same-cycle implication, muted while reset is asserted
`define ADSR_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, muted while reset is asserted
`define ADSR_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/adsr_pkg.sv
package adsr_pkg;

  // guard bits between sample and internal envelope format
  localparam int GUARD_BITS = 8;

  // configuration register index width
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ATTACK_POLE   = 3'd0,
    CFG_DECAY_POLE    = 3'd1,
    CFG_RELEASE_POLE  = 3'd2,
    CFG_SUSTAIN_LEVEL = 3'd3,
    CFG_ATTACK_PEAK   = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PH_CLEAR   = 2'd0,
    PH_ATTACK  = 2'd1,
    PH_DECAY   = 2'd2,
    PH_RELEASE = 2'd3
  } phase_e;

  // one strobe per datapath step
  typedef struct packed {
    logic load;
    logic target;
    logic diff;
    logic mul_lo;
    logic mul_hi;
    logic step;
    logic update;
    logic finish;
  } adsr_cmd_t;

endpackage

// File: src/adsr_in_if.sv
interface adsr_in_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] gate_level;

  modport source (output valid, output gate_level, input ready);
  modport sink (input valid, input gate_level, output ready);
endinterface

// File: src/adsr_out_if.sv
interface adsr_out_if import adsr_pkg::*; #(
  parameter int SAMPLE_BITS = 16
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] envelope;
  phase_e                 phase;

  modport source (output valid, output envelope, output phase, input ready);
  modport sink (input valid, input envelope, input phase, output ready);
endinterface

// File: src/adsr_envelope_one_pole_core.sv
// ADSR envelope generator with one-pole smoothing per phase.
// in_i carries one gate sample per word; out_o returns one envelope sample
// and the phase after that tick for every accepted gate word.
// Both channels use valid/ready; a word moves when both are high.
// Pole and level registers are written through cfg_we_i, cfg_index_i and
// cfg_data_i; the user must write them only while no sample is in flight,
// as the block itself does not enforce this. A new pole is used from the
// next phase change that selects it.
// After a gate word is accepted, the sequencer steps through the target,
// difference, two partial products of the step multiply, step sum,
// accumulator update and output rounding into the output register. One
// sample is in work at a time; the next word is taken once that is done.
// While the receiver stalls, a finished result waits in the output register
// and the next gate word is still taken and worked on; it completes only
// once the output register is free.
// Reset clears the phase to clear, the envelope accumulator, the previous
// gate and the active pole, and loads the default register values.
module adsr_envelope_one_pole_core import adsr_pkg::*; #(
  parameter int SAMPLE_BITS = 16,
  parameter int POLE_BITS   = 24,
  parameter int CFG_W       = (POLE_BITS > SAMPLE_BITS) ? POLE_BITS : SAMPLE_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  adsr_in_if.sink              in_i,
  adsr_out_if.source           out_o
);

  adsr_cmd_t              cmd;
  logic [POLE_BITS-1:0]   attack_pole;
  logic [POLE_BITS-1:0]   decay_pole;
  logic [POLE_BITS-1:0]   release_pole;
  logic [SAMPLE_BITS-1:0] sustain_level;
  logic [SAMPLE_BITS-1:0] attack_peak;

  // configuration registers
  adsr_cfg_regs #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .POLE_BITS  (POLE_BITS),
    .CFG_W      (CFG_W)
  ) u_cfg (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .attack_pole_o  (attack_pole),
    .decay_pole_o   (decay_pole),
    .release_pole_o (release_pole),
    .sustain_level_o(sustain_level),
    .attack_peak_o  (attack_peak)
  );

  // sequencer
  adsr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .out_ready_i(out_o.ready),
    .in_ready_o (in_i.ready),
    .out_valid_o(out_o.valid),
    .cmd_o      (cmd)
  );

  // filter datapath
  adsr_dpath #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .POLE_BITS  (POLE_BITS)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .gate_level_i   (in_i.gate_level),
    .attack_pole_i  (attack_pole),
    .decay_pole_i   (decay_pole),
    .release_pole_i (release_pole),
    .sustain_level_i(sustain_level),
    .attack_peak_i  (attack_peak),
    .envelope_o     (out_o.envelope),
    .phase_o        (out_o.phase)
  );

endmodule

// File: src/adsr_cfg_regs.sv
module adsr_cfg_regs import adsr_pkg::*; #(
  parameter int SAMPLE_BITS = 16,
  parameter int POLE_BITS   = 24,
  parameter int CFG_W       = 24
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_W-1:0]       cfg_data_i,
  output logic [POLE_BITS-1:0]   attack_pole_o,
  output logic [POLE_BITS-1:0]   decay_pole_o,
  output logic [POLE_BITS-1:0]   release_pole_o,
  output logic [SAMPLE_BITS-1:0] sustain_level_o,
  output logic [SAMPLE_BITS-1:0] attack_peak_o
);

  localparam logic [POLE_BITS-1:0]   AttackPoleRst  = POLE_BITS'(32'd16770874);
  localparam logic [POLE_BITS-1:0]   DecayPoleRst   = POLE_BITS'(32'd16773412);
  localparam logic [POLE_BITS-1:0]   ReleasePoleRst = POLE_BITS'(32'd16775948);
  localparam logic [SAMPLE_BITS-1:0] SustainRst     = SAMPLE_BITS'(1) << (SAMPLE_BITS - 2);
  localparam logic [SAMPLE_BITS-1:0] AttackPeakRst  = SAMPLE_BITS'(32'd32440);

  logic [POLE_BITS-1:0]   attack_pole_q;
  logic [POLE_BITS-1:0]   decay_pole_q;
  logic [POLE_BITS-1:0]   release_pole_q;
  logic [SAMPLE_BITS-1:0] sustain_level_q;
  logic [SAMPLE_BITS-1:0] attack_peak_q;

  // register writes, unknown indexes dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attack_pole_q   <= AttackPoleRst;
      decay_pole_q    <= DecayPoleRst;
      release_pole_q  <= ReleasePoleRst;
      sustain_level_q <= SustainRst;
      attack_peak_q   <= AttackPeakRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_ATTACK_POLE:   attack_pole_q   <= cfg_data_i[POLE_BITS-1:0];
        CFG_DECAY_POLE:    decay_pole_q    <= cfg_data_i[POLE_BITS-1:0];
        CFG_RELEASE_POLE:  release_pole_q  <= cfg_data_i[POLE_BITS-1:0];
        CFG_SUSTAIN_LEVEL: sustain_level_q <= cfg_data_i[SAMPLE_BITS-1:0];
        CFG_ATTACK_PEAK:   attack_peak_q   <= cfg_data_i[SAMPLE_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign attack_pole_o   = attack_pole_q;
  assign decay_pole_o    = decay_pole_q;
  assign release_pole_o  = release_pole_q;
  assign sustain_level_o = sustain_level_q;
  assign attack_peak_o   = attack_peak_q;

endmodule

// File: src/adsr_ctrl.sv
module adsr_ctrl import adsr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      out_ready_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  output adsr_cmd_t cmd_o
);

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_TGT  = 8'b0000_0010,
    ST_DIFF = 8'b0000_0100,
    ST_MLO  = 8'b0000_1000,
    ST_MHI  = 8'b0001_0000,
    ST_STEP = 8'b0010_0000,
    ST_UPD  = 8'b0100_0000,
    ST_OUT  = 8'b1000_0000
  } state_e;

  state_e    state_q, state_d;
  logic      out_valid_q, out_valid_d;
  adsr_cmd_t cmd;

  // sequencer through the filter step
  always_comb begin
    state_d = state_q;
    cmd     = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd.load = 1'b1;
          state_d  = ST_TGT;
        end
      end
      ST_TGT: begin
        cmd.target = 1'b1;
        state_d    = ST_DIFF;
      end
      ST_DIFF: begin
        cmd.diff = 1'b1;
        state_d  = ST_MLO;
      end
      ST_MLO: begin
        cmd.mul_lo = 1'b1;
        state_d    = ST_MHI;
      end
      ST_MHI: begin
        cmd.mul_hi = 1'b1;
        state_d    = ST_STEP;
      end
      ST_STEP: begin
        cmd.step = 1'b1;
        state_d  = ST_UPD;
      end
      ST_UPD: begin
        cmd.update = 1'b1;
        state_d    = ST_OUT;
      end
      ST_OUT: begin
        // wait for the output slot to be free
        if (!out_valid_q || out_ready_i) begin
          cmd.finish = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // output word valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd.finish) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

endmodule

// File: src/adsr_dpath.sv
module adsr_dpath import adsr_pkg::*; #(
  parameter int SAMPLE_BITS = 16,
  parameter int POLE_BITS   = 24
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  adsr_cmd_t              cmd_i,
  input  logic [SAMPLE_BITS-1:0] gate_level_i,
  input  logic [POLE_BITS-1:0]   attack_pole_i,
  input  logic [POLE_BITS-1:0]   decay_pole_i,
  input  logic [POLE_BITS-1:0]   release_pole_i,
  input  logic [SAMPLE_BITS-1:0] sustain_level_i,
  input  logic [SAMPLE_BITS-1:0] attack_peak_i,
  output logic [SAMPLE_BITS-1:0] envelope_o,
  output phase_e                 phase_o
);

  localparam int SW   = SAMPLE_BITS;
  localparam int PW   = POLE_BITS;
  localparam int AW   = SW + GUARD_BITS + 1;
  localparam int LW   = (AW + 1) / 2;
  localparam int HW   = AW - LW;
  localparam int BW   = PW + 1;
  localparam int SUMW = AW + BW;

  localparam logic [2*SW-1:0]  SusHalf  = (2*SW)'(1) << (SW - 2);
  localparam logic [LW+BW-1:0] StepHalf = (LW+BW)'(1) << (PW - 1);
  localparam logic [AW:0]      OutHalf  = (AW+1)'(1) << (GUARD_BITS - 1);

  // architectural state
  phase_e          phase_q;
  logic [SW-1:0]   prev_gate_q;
  logic [AW-1:0]   acc_q;
  logic [PW-1:0]   pole_q;

  // working registers
  logic [SW-1:0]    gate_q;
  logic [2*SW-1:0]  prod_q;
  logic [AW-1:0]    tgt_q;
  logic [AW-1:0]    d_q;
  logic             up_q;
  logic [LW+BW-1:0] lo_q;
  logic [LW+BW-1:0] lor_q;
  logic [HW+BW-1:0] hi_q;
  logic [AW-1:0]    step_q;
  logic [SW-1:0]    env_q;
  phase_e           phase_out_q;

  phase_e           phase_ld;
  logic [PW-1:0]    pole_ld;
  logic [2*SW-1:0]  sus_sum;
  logic [AW-1:0]    tgt_d;
  logic             up_d;
  logic [AW-1:0]    d_d;
  logic [BW-1:0]    coef;
  logic [SUMW-1:0]  sum_w;
  logic [AW:0]      acc_rnd;
  logic [SW+1:0]    out_v;
  logic [SW-1:0]    env_sat;
  logic             peak_hit;
  phase_e           phase_fin;

  // phase change on gate edges
  always_comb begin
    phase_ld = phase_q;
    pole_ld  = pole_q;
    if (prev_gate_q < gate_level_i && phase_q != PH_DECAY) begin
      phase_ld = PH_ATTACK;
      pole_ld  = attack_pole_i;
    end else if (prev_gate_q > gate_level_i) begin
      phase_ld = PH_RELEASE;
      pole_ld  = release_pole_i;
    end
  end

  // filter target: gate in attack, gate times sustain otherwise
  assign sus_sum = prod_q + SusHalf;
  assign tgt_d   = (phase_q == PH_ATTACK) ?
                   {1'b0, gate_q, {GUARD_BITS{1'b0}}} :
                   {sus_sum[2*SW-1:SW-1], {GUARD_BITS{1'b0}}};

  // distance to target and direction
  assign up_d = (tgt_q >= acc_q);
  assign d_d  = up_d ? (tgt_q - acc_q) : (acc_q - tgt_q);

  // one minus pole, a zero pole gives a full step
  assign coef = (BW'(1) << PW) - {1'b0, pole_q};

  // rounded step from the two partial products
  assign sum_w = {hi_q, {LW{1'b0}}} + SUMW'(lor_q);

  // output rounding and saturation
  assign acc_rnd  = {1'b0, acc_q} + OutHalf;
  assign out_v    = acc_rnd[AW:GUARD_BITS];
  assign env_sat  = (|out_v[SW+1:SW]) ? {SW{1'b1}} : out_v[SW-1:0];
  assign peak_hit = (phase_q == PH_ATTACK) && (env_sat > attack_peak_i);
  assign phase_fin = peak_hit ? PH_DECAY : phase_q;

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_CLEAR;
      prev_gate_q <= '0;
      acc_q       <= '0;
      pole_q      <= '0;
    end else begin
      if (cmd_i.load) begin
        phase_q     <= phase_ld;
        pole_q      <= pole_ld;
        prev_gate_q <= gate_level_i;
      end
      if (cmd_i.update && phase_q != PH_CLEAR) begin
        acc_q <= up_q ? (acc_q + step_q) : (acc_q - step_q);
      end
      if (cmd_i.finish && peak_hit) begin
        phase_q <= PH_DECAY;
        pole_q  <= decay_pole_i;
      end
    end
  end

  // working and output registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      gate_q <= gate_level_i;
      prod_q <= (2*SW)'(gate_level_i) * (2*SW)'(sustain_level_i);
    end
    if (cmd_i.target) begin
      tgt_q <= tgt_d;
    end
    if (cmd_i.diff) begin
      d_q  <= d_d;
      up_q <= up_d;
    end
    if (cmd_i.mul_lo) begin
      lo_q <= (LW+BW)'(d_q[LW-1:0]) * (LW+BW)'(coef);
    end
    if (cmd_i.mul_hi) begin
      hi_q  <= (HW+BW)'(d_q[AW-1:LW]) * (HW+BW)'(coef);
      lor_q <= lo_q + StepHalf;
    end
    if (cmd_i.step) begin
      step_q <= sum_w[PW +: AW];
    end
    if (cmd_i.finish) begin
      env_q       <= (phase_q == PH_CLEAR) ? '0 : env_sat;
      phase_out_q <= phase_fin;
    end
  end

  assign envelope_o = env_q;
  assign phase_o    = phase_out_q;

endmodule

// File: src/adsr_core_checker.sv
`include "adsr_envelope_one_pole_core_macros.svh"

module adsr_core_checker import adsr_pkg::*; #(
  parameter int SAMPLE_BITS = 16
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_ready_i,
  input logic                   out_valid_i,
  input logic                   out_ready_i,
  input logic [SAMPLE_BITS-1:0] envelope_i,
  input phase_e                 phase_i
);

  // a stalled result word holds still
  `ADSR_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(envelope_i) && $stable(phase_i), "output word changed under stall")

  // one sample in work at a time
  `ADSR_ASSERT_NXT(a_one_in_flight, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i, "input taken while a sample is in work")

  // clear phase gives a silent envelope
  `ADSR_ASSERT_IMP(a_clear_silent, clk_i, rst_ni, out_valid_i && phase_i == PH_CLEAR, envelope_i == '0, "nonzero envelope in clear phase")

endmodule

bind adsr_envelope_one_pole_core adsr_core_checker #(
  .SAMPLE_BITS(SAMPLE_BITS)
) u_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_i.valid),
  .in_ready_i (in_i.ready),
  .out_valid_i(out_o.valid),
  .out_ready_i(out_o.ready),
  .envelope_i (out_o.envelope),
  .phase_i    (out_o.phase)
);
